>>> hdl/fvp_pkg.sv
// Shared constants, types and helpers for the feature vector projection block.
// No dependencies; every other file in this folder uses it, apart from fvp_ram.
`timescale 1ns / 1ps

package fvp_pkg;

  localparam int IN_LENGTH  = 16;
  localparam int OUT_LENGTH = 8;

  localparam int KIND_W  = 1;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 16;
  localparam int COMP_W  = 3;
  localparam int PROJ_W  = 36;
  localparam int PROD_W  = 2 * VAL_W;

  localparam int POS_W   = (IN_LENGTH > 1) ? $clog2(IN_LENGTH) : 1;
  localparam int ROW_W   = (OUT_LENGTH > 1) ? $clog2(OUT_LENGTH) : 1;
  localparam int CNT_W   = $clog2(OUT_LENGTH + 1);
  localparam int IDX_EXT_W = 12;

  // Sums are kept exact; the accumulator never narrows below the result field.
  localparam int ACC_W = (PROD_W + $clog2(IN_LENGTH) > PROJ_W) ?
                         (PROD_W + $clog2(IN_LENGTH)) : PROJ_W;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FEATURE = 1'b1;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(IN_LENGTH - 1);

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROJ_W-1:0] proj_t;

  // Control and shared data handed from the top level to every lane.
  typedef struct packed {
    logic             adv;
    logic             ld_en;
    logic [IDX_W-1:0] ld_index;
    val_t             ld_value;
    logic [POS_W-1:0] rd_pos;
    val_t             s1_value;
    logic             s2_valid;
    logic             s2_last;
  } lane_ctrl_t;

  // Clamp an exact sum to the signed result range.
  function automatic proj_t sat_proj(input acc_t s);
    logic [ACC_W-PROJ_W:0] top_bits;
    proj_t                 res;
    top_bits = s[ACC_W-1:PROJ_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      res = s[PROJ_W-1:0];
    end else if (s[ACC_W-1]) begin
      res = {1'b1, {(PROJ_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(PROJ_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> hdl/fvp_intf.sv
// Valid/ready channel interfaces for the input and result streams.
// Depends on fvp_pkg for field widths.
`timescale 1ns / 1ps

interface fvp_in_if;
  logic                      valid;
  logic                      ready;
  logic [fvp_pkg::KIND_W-1:0] kind;
  logic [fvp_pkg::IDX_W-1:0]  coeff_index;
  logic signed [fvp_pkg::VAL_W-1:0] value;

  modport source (output valid, kind, coeff_index, value, input ready);
  modport sink   (input valid, kind, coeff_index, value, output ready);
endinterface

interface fvp_out_if;
  logic                       valid;
  logic                       ready;
  logic [fvp_pkg::COMP_W-1:0] component;
  logic signed [fvp_pkg::PROJ_W-1:0] projection;
  logic                       last_component;

  modport source (output valid, component, projection, last_component, input ready);
  modport sink   (input valid, component, projection, last_component, output ready);
endinterface

>>> hdl/fvp_ram.sv
// Generic single-port-write, single-port-read memory with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module fvp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/fvp_lane.sv
// One basis row: its coefficient memory, a registered multiplier and the
// row accumulator. Depends on fvp_pkg and fvp_ram.
`timescale 1ns / 1ps

module fvp_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [fvp_pkg::ROW_W-1:0] row,
  input  fvp_pkg::lane_ctrl_t ctrl,
  output fvp_pkg::proj_t     proj
);
  import fvp_pkg::*;

  logic [IDX_EXT_W-1:0] idx_ext;
  logic [IDX_EXT_W-1:0] base;
  logic [IDX_EXT_W-1:0] offs;
  logic                 hit;
  logic [VAL_W-1:0]     coeff;
  prod_t                prod_r;
  prod_t                prod_nxt;
  acc_t                 acc_r;
  acc_t                 acc_nxt;
  acc_t                 sum;

  // A load lands in this row when its address falls inside the row's span.
  assign idx_ext = IDX_EXT_W'(ctrl.ld_index);
  assign base    = IDX_EXT_W'(row) * IDX_EXT_W'(IN_LENGTH);
  assign offs    = idx_ext - base;
  assign hit     = (idx_ext >= base) && (offs < IDX_EXT_W'(IN_LENGTH));

  fvp_ram #(
    .DEPTH(IN_LENGTH),
    .WIDTH(VAL_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ctrl.ld_en && hit),
    .wr_addr(offs[POS_W-1:0]),
    .wr_data(ctrl.ld_value),
    .rd_en  (ctrl.adv),
    .rd_addr(ctrl.rd_pos),
    .rd_data(coeff)
  );

  assign prod_nxt = $signed(coeff) * ctrl.s1_value;
  assign sum      = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.adv && ctrl.s2_valid) begin
      acc_nxt = ctrl.s2_last ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign proj = sat_proj(sum);

endmodule

>>> hdl/fvp_drain.sv
// Result bank: holds the finished projections of one vector and shifts them
// out one beat at a time. Depends on fvp_pkg and fvp_intf.
`timescale 1ns / 1ps

module fvp_drain (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  fvp_pkg::proj_t data [fvp_pkg::OUT_LENGTH],
  output logic           busy,
  fvp_out_if.source      out_ch
);
  import fvp_pkg::*;

  proj_t            bank_r   [OUT_LENGTH];
  proj_t            bank_nxt [OUT_LENGTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [ROW_W-1:0] comp_r;
  logic [ROW_W-1:0] comp_nxt;
  logic             pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    comp_nxt = comp_r;
    if (load) begin
      bank_nxt = data;
      cnt_nxt  = CNT_W'(OUT_LENGTH);
      comp_nxt = '0;
    end else if (pop) begin
      for (int i = 0; i < OUT_LENGTH - 1; i++) begin
        bank_nxt[i] = bank_r[i+1];
      end
      cnt_nxt  = cnt_r - 1'b1;
      comp_nxt = (cnt_r == CNT_W'(1)) ? '0 : comp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      comp_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      comp_r <= comp_nxt;
    end
  end

  assign busy                  = (cnt_r != '0);
  assign out_ch.valid          = busy;
  assign out_ch.component      = COMP_W'(comp_r);
  assign out_ch.projection     = bank_r[0];
  assign out_ch.last_component = (cnt_r == CNT_W'(1));

endmodule

>>> hdl/feature_vector_projection.sv
// A vector's last element passes the RAM and s1 registers, prod_r and the result bank.
// Throughput: one input beat per cycle unless stalled; results one per cycle while ready.
// The input stalls only when a new vector finishes while the bank still holds the last one.
// Reset (rst_n, synchronous, active low) clears accumulators, position and pipeline valids;
// coefficient memories are not cleared and must be loaded before use.
`timescale 1ns / 1ps

module feature_vector_projection (
  input  logic     clk,
  input  logic     rst_n,
  fvp_in_if.sink   in_ch,
  fvp_out_if.source out_ch
);
  import fvp_pkg::*;

  logic             adv;
  logic             acc_beat;
  logic             feat_acc;
  logic             dump;
  logic             busy;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             s1_valid_r;
  logic             s1_last_r;
  val_t             s1_value_r;
  logic             s2_valid_r;
  logic             s2_last_r;
  lane_ctrl_t       ctrl;
  proj_t            lane_proj [OUT_LENGTH];

  // The pipeline stops only when a finished vector cannot enter the bank.
  assign adv      = !(s2_valid_r && s2_last_r && busy);
  assign in_ch.ready = adv;
  assign acc_beat = in_ch.valid && in_ch.ready;
  assign feat_acc = acc_beat && (in_ch.kind == KIND_FEATURE);
  assign dump     = adv && s2_valid_r && s2_last_r;

  always_comb begin
    pos_nxt = pos_r;
    if (feat_acc) begin
      pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (adv) begin
        s1_valid_r <= feat_acc;
        s1_last_r  <= feat_acc && (pos_r == POS_LAST);
        s2_valid_r <= s1_valid_r;
        s2_last_r  <= s1_valid_r && s1_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_value_r <= in_ch.value;
    end
  end

  always_comb begin
    ctrl.adv      = adv;
    ctrl.ld_en    = acc_beat && (in_ch.kind == KIND_LOAD);
    ctrl.ld_index = in_ch.coeff_index;
    ctrl.ld_value = in_ch.value;
    ctrl.rd_pos   = pos_r;
    ctrl.s1_value = s1_value_r;
    ctrl.s2_valid = s2_valid_r;
    ctrl.s2_last  = s2_last_r;
  end

  for (genvar r = 0; r < OUT_LENGTH; r++) begin : g_lane
    fvp_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .row  (ROW_W'(r)),
      .ctrl (ctrl),
      .proj (lane_proj[r])
    );
  end

  fvp_drain u_drain (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (dump),
    .data  (lane_proj),
    .busy  (busy),
    .out_ch(out_ch)
  );

  // A finished vector must never overwrite results still waiting in the bank.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dump |-> !busy)
    else $error("vector dumped into a busy result bank");

  // The first beat after a dump is component zero.
  a_first_comp: assert property (@(posedge clk) disable iff (!rst_n)
    dump |=> (out_ch.valid && out_ch.component == '0))
    else $error("result bank did not start at component zero");

  // An element accepted at the final position is tagged as the end of a vector.
  a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (feat_acc && pos_r == POS_LAST) |=> (s1_valid_r && s1_last_r && pos_r == '0))
    else $error("end of vector not tagged");

endmodule

>>> tb/feature_vector_projection_tb.sv
// Self-checking testbench for feature_vector_projection: coefficient loads and feature beats
// are driven with random idling and back-pressure, and every projection is checked against
// a local predictor. Depends on fvp_pkg and the channel interfaces in hdl/fvp_intf.sv.
`timescale 1ns / 1ps

module feature_vector_projection_tb;
  import fvp_pkg::*;

  localparam int BASIS_DEPTH = OUT_LENGTH * IN_LENGTH;

  typedef struct {
    logic [COMP_W-1:0]        component;
    logic signed [PROJ_W-1:0] projection;
    logic                     last_component;
  } projection_t;

  logic clk;
  logic rst_n;

  fvp_in_if  in_ch ();
  fvp_out_if out_ch ();

  feature_vector_projection uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state.
  val_t        basis [BASIS_DEPTH];
  longint      row_sum [OUT_LENGTH];
  int          elem_pos;
  projection_t pending_projections [$];

  int mismatches;
  int in_idle_pct;
  int out_idle_pct;
  int hold_off_left;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Mirrors the block for one accepted beat and queues the projections it completes.
  task automatic project_beat(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                              input val_t value);
    projection_t res;
    longint      lim;
    longint      s;
    lim = (longint'(1) <<< (PROJ_W - 1)) - 1;
    if (kind == KIND_LOAD) begin
      if (int'(idx) < BASIS_DEPTH) begin
        basis[idx] = value;
      end
    end else begin
      for (int r = 0; r < OUT_LENGTH; r++) begin
        row_sum[r] += longint'(basis[r * IN_LENGTH + elem_pos]) * longint'(value);
      end
      elem_pos++;
      if (elem_pos == IN_LENGTH) begin
        elem_pos = 0;
        for (int r = 0; r < OUT_LENGTH; r++) begin
          s = row_sum[r];
          if (s > lim) begin
            s = lim;
          end else if (s < -lim - 1) begin
            s = -lim - 1;
          end
          res.component      = COMP_W'(r);
          res.projection     = PROJ_W'(s);
          res.last_component = (r == OUT_LENGTH - 1);
          pending_projections.push_back(res);
          row_sum[r] = 0;
        end
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                           input val_t value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.coeff_index <= idx;
    in_ch.value       <= value;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    project_beat(kind, idx, value);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_projections.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic val_t pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 6) begin
      return val_t'(16'sh8000);
    end else if (sel < 12) begin
      return val_t'(16'sh7fff);
    end else if (sel < 15) begin
      return '0;
    end
    return val_t'($urandom_range(16'hffff));
  endfunction

  // Every coefficient is written before any feature beat reads it. Row 0 holds the most
  // negative value and row 1 the most positive, so the extreme vector hits both ends.
  task automatic test_basis_load();
    val_t v;
    for (int a = 0; a < BASIS_DEPTH; a++) begin
      if (a / IN_LENGTH == 0) begin
        v = val_t'(16'sh8000);
      end else if (a / IN_LENGTH == 1) begin
        v = val_t'(16'sh7fff);
      end else begin
        v = pick_value();
      end
      send_beat(KIND_LOAD, IDX_W'(a), v);
    end
    drain_results();
  endtask

  // A vector of most negative elements gives the largest and smallest sums; a load in the
  // middle of the vector must only affect the elements after it.
  task automatic test_extreme_vector();
    for (int e = 0; e < IN_LENGTH; e++) begin
      if (e == IN_LENGTH / 2) begin
        send_beat(KIND_LOAD, IDX_W'(2 * IN_LENGTH + e), val_t'(16'sh7fff));
        send_beat(KIND_LOAD, IDX_W'(2 * IN_LENGTH + e - 1), val_t'(16'sh8000));
      end
      send_beat(KIND_FEATURE, '0, val_t'(16'sh8000));
    end
    drain_results();
  endtask

  task automatic test_random_stream(input int n_beats);
    for (int i = 0; i < n_beats; i++) begin
      if ($urandom_range(99) < 18) begin
        send_beat(KIND_LOAD, IDX_W'($urandom_range(BASIS_DEPTH - 1)), pick_value());
      end else begin
        send_beat(KIND_FEATURE, IDX_W'($urandom_range(BASIS_DEPTH - 1)), pick_value());
      end
    end
    drain_results();
  endtask

  task automatic test_back_to_back();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_stream(48);
    in_idle_pct  = 19;
    out_idle_pct = 19;
  endtask

  // The receiver holds off long enough for several vectors to finish, so the result bank
  // fills and the input has to stall.
  task automatic test_output_backpressure();
    in_idle_pct   = 0;
    hold_off_left = 200;
    for (int i = 0; i < 3 * IN_LENGTH; i++) begin
      send_beat(KIND_FEATURE, '0, pick_value());
    end
    in_idle_pct = 19;
    drain_results();
  endtask

  // Receiver side.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    projection_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_projections.size() == 0) begin
        report_mismatch("unexpected projection", out_ch.projection, 0);
      end else begin
        want = pending_projections.pop_front();
        if (out_ch.component !== want.component) begin
          report_mismatch("component", out_ch.component, want.component);
        end
        if (out_ch.projection !== want.projection) begin
          report_mismatch("projection", out_ch.projection, want.projection);
        end
        if (out_ch.last_component !== want.last_component) begin
          report_mismatch("last_component", out_ch.last_component, want.last_component);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL feature_vector_projection");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_LOAD;
    in_ch.coeff_index = '0;
    in_ch.value       = '0;
    mismatches        = 0;
    in_idle_pct       = 19;
    out_idle_pct      = 19;
    hold_off_left     = 0;
    elem_pos          = 0;
    for (int r = 0; r < OUT_LENGTH; r++) begin
      row_sum[r] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basis_load();
    test_extreme_vector();
    test_random_stream(40);
    test_back_to_back();
    test_output_backpressure();
    test_random_stream(30);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS feature_vector_projection");
    end else begin
      $display("FAIL feature_vector_projection");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/fvp_pkg.sv
hdl/fvp_intf.sv
hdl/fvp_ram.sv
hdl/fvp_lane.sv
hdl/fvp_drain.sv
hdl/feature_vector_projection.sv
tb/feature_vector_projection_tb.sv
